>>> design/sidlc_pkg.sv
// Package for the sorted ID list cursor.
// Holds the command, status and state codes and the controller/datapath structs.
// No dependencies.
package sidlc_pkg;

	localparam int POS_W    = 11;   // cursor position and list length width
	localparam int IDX_W    = 10;   // entry index width on the input
	localparam int OUT_ID_W = 64;   // ID width on the ports

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SKIP   = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_END      = 2'd2,
		ST_ORDER    = 2'd3
	} status_t;

	// Read address sources for the list store
	typedef enum logic [1:0] {
		RD_POS  = 2'd0,
		RD_LAST = 2'd1,
		RD_MID  = 2'd2,
		RD_NEXT = 2'd3
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ_WAIT,
		S_SKIP_LAST,
		S_PROBE,
		S_PROBE_WAIT,
		S_FINISH,
		S_STEP_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    latch_in;
		logic    mem_write;
		logic    mem_read;
		rd_sel_t rd_sel;
		logic    load_mid;
		logic    clear_cursor;
		logic    set_end;
		logic    take_read;
		logic    init_search;
		logic    probe_update;
		logic    step_index;
		logic    commit_val;
		logic    commit_rdata;
		logic    status_load;
		status_t status_code;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic at_end;
		logic pos_at_len;
		logic past_last_entry;
		logic not_above_last;
		logic hit;
		logic search_more;
		logic val_below;
		logic val_hit;
		logic next_past_end;
	} dp_stat_t;

endpackage

>>> design/sidlc_dpath.sv
// Datapath of the sorted ID list cursor: list store, cursor state,
// binary search registers and output register. Uses sidlc_pkg.
module sidlc_dpath #(
	parameter int LIST_DEPTH = 1024,
	parameter int ID_WIDTH   = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [sidlc_pkg::POS_W-1:0]         cfg_write_data,
	input  logic [1:0]                          command,
	input  logic [sidlc_pkg::IDX_W-1:0]         entry_index,
	input  logic [sidlc_pkg::OUT_ID_W-1:0]      doc_id,
	input  sidlc_pkg::dp_cmd_t                  cmd,
	output sidlc_pkg::dp_stat_t                 stat,
	output logic [1:0]                          status,
	output logic [sidlc_pkg::OUT_ID_W-1:0]      current_id,
	output logic [sidlc_pkg::POS_W-1:0]         cursor_position
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int PW = sidlc_pkg::POS_W;

	logic [ID_WIDTH-1:0] mem [LIST_DEPTH];

	logic [PW-1:0]                len_q;
	logic [PW-1:0]                rp_q;
	logic [ID_WIDTH-1:0]          last_id_q;
	logic                         at_end_q;
	sidlc_pkg::cmd_t              cmd_q;
	logic [sidlc_pkg::IDX_W-1:0]  idx_q;
	logic [ID_WIDTH-1:0]          target_q;
	logic [ID_WIDTH-1:0]          span_q;
	logic [ID_WIDTH-1:0]          rdata_q;
	logic [ID_WIDTH-1:0]          val_q;
	logic [PW-1:0]                lo_q;
	logic [PW-1:0]                hi_q;
	logic [PW-1:0]                i_q;
	sidlc_pkg::status_t           status_q;
	logic [1:0]                   out_status_q;
	logic [ID_WIDTH-1:0]          out_id_q;
	logic [PW-1:0]                out_pos_q;

	logic [PW:0]   mid_sum;
	logic [PW-1:0] mid;
	logic [PW:0]   i_next_w;
	logic [PW-1:0] i_next;
	logic [PW-1:0] new_lo;
	logic [PW-1:0] new_hi;
	logic [PW-1:0] rem;
	logic [PW-1:0] hi_init;
	logic [PW-1:0] rd_pos;
	logic [AW-1:0] rd_addr;
	logic          idx_ok;
	logic [PW-1:0] len_eff;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[PW:1];
	assign i_next_w = {1'b0, i_q} + {{PW{1'b0}}, 1'b1};
	assign i_next   = i_next_w[PW-1:0];
	assign rem      = len_q - rp_q;
	assign hi_init  = (span_q >= ID_WIDTH'(rem)) ? len_q : rp_q + span_q[PW-1:0];
	assign idx_ok   = (32'(idx_q) < 32'(LIST_DEPTH));
	assign len_eff  = (32'(cfg_write_data) > 32'(LIST_DEPTH)) ? PW'(LIST_DEPTH) : cfg_write_data;

	always_comb begin
		if (target_q < rdata_q) begin
			new_lo = lo_q;
			new_hi = i_q;
		end else begin
			new_lo = i_next;
			new_hi = hi_q;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			sidlc_pkg::RD_POS:  rd_pos = rp_q;
			sidlc_pkg::RD_LAST: rd_pos = len_q - {{(PW-1){1'b0}}, 1'b1};
			sidlc_pkg::RD_MID:  rd_pos = mid;
			default:            rd_pos = i_next;
		endcase
	end

	assign rd_addr = AW'(rd_pos);

	// List store: one write port, one read port, registered read data
	always_ff @(posedge clk) begin
		if (cmd.mem_write && idx_ok) begin
			mem[AW'(idx_q)] <= target_q;
		end
		if (cmd.mem_read) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Cursor state and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			rp_q      <= '0;
			last_id_q <= '0;
			at_end_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				len_q <= len_eff;
			end
			if (cmd.clear_cursor) begin
				rp_q      <= '0;
				last_id_q <= '0;
				at_end_q  <= 1'b0;
			end
			if (cmd.set_end) begin
				at_end_q <= 1'b1;
			end
			if (cmd.take_read) begin
				last_id_q <= rdata_q;
				rp_q      <= rp_q + {{(PW-1){1'b0}}, 1'b1};
			end
			if (cmd.commit_val) begin
				last_id_q <= val_q;
				rp_q      <= i_next;
			end
			if (cmd.commit_rdata) begin
				last_id_q <= rdata_q;
				rp_q      <= i_next;
			end
		end
	end

	// Transaction and search registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q    <= sidlc_pkg::cmd_t'(command);
			idx_q    <= entry_index;
			target_q <= doc_id[ID_WIDTH-1:0];
			span_q   <= doc_id[ID_WIDTH-1:0] - last_id_q;
		end
		if (cmd.init_search) begin
			lo_q <= rp_q;
			hi_q <= hi_init;
		end
		if (cmd.load_mid) begin
			i_q <= mid;
		end
		if (cmd.probe_update) begin
			val_q <= rdata_q;
			lo_q  <= new_lo;
			hi_q  <= new_hi;
		end
		if (cmd.step_index) begin
			i_q <= i_next;
		end
		if (cmd.status_load) begin
			status_q <= cmd.status_code;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_id_q     <= last_id_q;
			out_pos_q    <= rp_q;
		end
	end

	assign stat.cmd             = cmd_q;
	assign stat.at_end          = at_end_q;
	assign stat.pos_at_len      = (rp_q >= len_q);
	assign stat.past_last_entry = (target_q > rdata_q);
	assign stat.not_above_last  = (target_q <= last_id_q);
	assign stat.hit             = (rdata_q == target_q);
	assign stat.search_more     = (new_lo < new_hi);
	assign stat.val_below       = (val_q < target_q);
	assign stat.val_hit         = (val_q == target_q);
	assign stat.next_past_end   = (i_next_w >= {1'b0, len_q});

	assign status          = out_status_q;
	assign current_id      = sidlc_pkg::OUT_ID_W'(out_id_q);
	assign cursor_position = out_pos_q;

endmodule

>>> design/sidlc_ctrl.sv
// Controller of the sorted ID list cursor: sequences each transaction and
// owns the handshake flags. Uses sidlc_pkg; drives sidlc_dpath.
module sidlc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  sidlc_pkg::dp_stat_t  stat,
	output sidlc_pkg::dp_cmd_t   cmd
);

	sidlc_pkg::state_t state_q;
	sidlc_pkg::state_t state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != sidlc_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sidlc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sidlc_pkg::S_IDLE: begin
				if (in_valid) state_d = sidlc_pkg::S_DECODE;
			end
			sidlc_pkg::S_DECODE: begin
				unique case (stat.cmd)
					sidlc_pkg::CMD_READ: begin
						if (stat.at_end || stat.pos_at_len) state_d = sidlc_pkg::S_DONE;
						else state_d = sidlc_pkg::S_READ_WAIT;
					end
					sidlc_pkg::CMD_SKIP: begin
						if (stat.at_end || stat.pos_at_len) state_d = sidlc_pkg::S_DONE;
						else state_d = sidlc_pkg::S_SKIP_LAST;
					end
					default: state_d = sidlc_pkg::S_DONE;
				endcase
			end
			sidlc_pkg::S_READ_WAIT: state_d = sidlc_pkg::S_DONE;
			sidlc_pkg::S_SKIP_LAST: begin
				if (stat.past_last_entry || stat.not_above_last) state_d = sidlc_pkg::S_DONE;
				else state_d = sidlc_pkg::S_PROBE;
			end
			sidlc_pkg::S_PROBE: state_d = sidlc_pkg::S_PROBE_WAIT;
			sidlc_pkg::S_PROBE_WAIT: begin
				if (!stat.hit && stat.search_more) state_d = sidlc_pkg::S_PROBE;
				else state_d = sidlc_pkg::S_FINISH;
			end
			sidlc_pkg::S_FINISH: begin
				if (stat.val_below && !stat.next_past_end) state_d = sidlc_pkg::S_STEP_WAIT;
				else state_d = sidlc_pkg::S_DONE;
			end
			sidlc_pkg::S_STEP_WAIT: state_d = sidlc_pkg::S_DONE;
			sidlc_pkg::S_DONE: begin
				if (out_free) state_d = sidlc_pkg::S_IDLE;
			end
			default: state_d = sidlc_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			sidlc_pkg::S_IDLE: begin
				cmd.latch_in = in_valid;
			end
			sidlc_pkg::S_DECODE: begin
				cmd.status_load = 1'b1;
				cmd.status_code = sidlc_pkg::ST_OK;
				unique case (stat.cmd)
					sidlc_pkg::CMD_LOAD: begin
						cmd.mem_write = 1'b1;
					end
					sidlc_pkg::CMD_READ: begin
						if (stat.at_end || stat.pos_at_len) begin
							cmd.set_end     = 1'b1;
							cmd.status_code = sidlc_pkg::ST_END;
						end else begin
							cmd.mem_read = 1'b1;
							cmd.rd_sel   = sidlc_pkg::RD_POS;
						end
					end
					sidlc_pkg::CMD_SKIP: begin
						if (stat.at_end || stat.pos_at_len) begin
							cmd.set_end     = 1'b1;
							cmd.status_code = sidlc_pkg::ST_END;
						end else begin
							cmd.mem_read = 1'b1;
							cmd.rd_sel   = sidlc_pkg::RD_LAST;
						end
					end
					default: begin
						cmd.clear_cursor = 1'b1;
					end
				endcase
			end
			sidlc_pkg::S_READ_WAIT: begin
				cmd.take_read = 1'b1;
			end
			sidlc_pkg::S_SKIP_LAST: begin
				if (stat.past_last_entry) begin
					cmd.set_end     = 1'b1;
					cmd.status_load = 1'b1;
					cmd.status_code = sidlc_pkg::ST_END;
				end else if (stat.not_above_last) begin
					cmd.status_load = 1'b1;
					cmd.status_code = sidlc_pkg::ST_ORDER;
				end else begin
					cmd.init_search = 1'b1;
				end
			end
			sidlc_pkg::S_PROBE: begin
				cmd.mem_read = 1'b1;
				cmd.rd_sel   = sidlc_pkg::RD_MID;
				cmd.load_mid = 1'b1;
			end
			sidlc_pkg::S_PROBE_WAIT: begin
				cmd.probe_update = 1'b1;
			end
			sidlc_pkg::S_FINISH: begin
				cmd.status_load = 1'b1;
				if (stat.val_below) begin
					if (stat.next_past_end) begin
						cmd.set_end     = 1'b1;
						cmd.status_code = sidlc_pkg::ST_END;
					end else begin
						cmd.mem_read   = 1'b1;
						cmd.rd_sel     = sidlc_pkg::RD_NEXT;
						cmd.step_index = 1'b1;
					end
				end else begin
					cmd.commit_val  = 1'b1;
					cmd.status_code = stat.val_hit ? sidlc_pkg::ST_OK : sidlc_pkg::ST_NOTFOUND;
				end
			end
			sidlc_pkg::S_STEP_WAIT: begin
				cmd.commit_rdata = 1'b1;
				cmd.status_load  = 1'b1;
				cmd.status_code  = stat.hit ? sidlc_pkg::ST_OK : sidlc_pkg::ST_NOTFOUND;
			end
			sidlc_pkg::S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> design/sorted_id_list_cursor_top.sv
// Top level of the sorted ID list cursor.
// Instantiates sidlc_ctrl and sidlc_dpath; uses sidlc_pkg.
//
// Cursor over a stored, strictly increasing list of IDs. Each transaction
// carries a command: load writes doc_id at entry_index, read steps the
// cursor to the next ID, skip binary searches from the cursor for doc_id
// (within a window no wider than the distance from the last returned ID),
// and rewind puts the cursor back to the start. Every transaction yields
// exactly one result: status, the ID the cursor now stands on and the index
// of the next entry. Write list_length only while the block is idle; values
// above LIST_DEPTH act as LIST_DEPTH. Items are taken one at a time: load
// and rewind go from decode straight to the result, and so do read and
// skip once the cursor is at the end. Otherwise read waits for the store
// read, and skip reads the last entry for the end and order checks, then
// binary searches, each probe a store read followed by a wait state, and
// reads once more when it has to step to the next larger entry. The probe
// count is at most ceil(log2 of the search window) + 1. The pace is set by
// the single read port of the list store, whose read data is registered.
// A new transaction is accepted while the previous result still waits in
// the output register. The store has no reset: entries must be loaded
// before the cursor reaches them.
module sorted_id_list_cursor_top #(
	parameter int LIST_DEPTH = 1024,
	parameter int ID_WIDTH   = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration: list_length
	input  logic                                cfg_write_en,
	input  logic [sidlc_pkg::POS_W-1:0]         cfg_write_data,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic [sidlc_pkg::IDX_W-1:0]         entry_index,
	input  logic [sidlc_pkg::OUT_ID_W-1:0]      doc_id,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [sidlc_pkg::OUT_ID_W-1:0]      current_id,
	output logic [sidlc_pkg::POS_W-1:0]         cursor_position
);

	sidlc_pkg::dp_cmd_t  dp_cmd;
	sidlc_pkg::dp_stat_t dp_stat;

	// Sequence each transaction: decode, memory probes, result hand-off
	sidlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Hold the list store, cursor state, search window and output register
	sidlc_dpath #(
		.LIST_DEPTH (LIST_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.command         (command),
		.entry_index     (entry_index),
		.doc_id          (doc_id),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.status          (status),
		.current_id      (current_id),
		.cursor_position (cursor_position)
	);

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Testbench for the sorted ID list cursor: loads, reads, skips and rewinds under random flow
// control on both channels, each result checked against a transaction-level cursor model.
// Depends on sidlc_pkg and sorted_id_list_cursor_top.
module testbench;

	localparam int DEPTH      = 1024;
	// Allow plenty of headroom over a slow skip and the longest result stall.
	localparam int IDLE_LIMIT = 4000;

	// How densely a loaded list is spread over the ID space
	typedef enum {GAP_DENSE, GAP_NARROW, GAP_WIDE, GAP_TOP} spacing_t;

	// Result-side stall patterns
	typedef enum {FLOW_FREE, FLOW_COIN, FLOW_RUNS, FLOW_SPARSE} rx_mode_t;

	typedef struct packed {
		sidlc_pkg::status_t st;
		logic [63:0]        id;
		logic [10:0]        pos;
	} cursor_result_t;

	// Cursor model and result queue. note_command advances the model by one
	// accepted transaction and queues the result it must produce;
	// check_result compares a delivered result with the oldest one queued.
	class cursor_checker;
		bit [63:0]      id_mem [DEPTH];
		bit [10:0]      list_len;
		bit [10:0]      next_pos;
		bit [63:0]      last_id;
		bit             at_end;
		cursor_result_t awaited [$];
		int             errors;

		// Lengths above the store depth behave as the full store
		function int unsigned active_len();
			return (list_len > DEPTH) ? DEPTH : int'(list_len);
		endfunction

		function sidlc_pkg::status_t read_next();
			if (at_end || next_pos >= active_len()) begin
				at_end = 1'b1;
				return sidlc_pkg::ST_END;
			end
			last_id = id_mem[next_pos];
			next_pos++;
			return sidlc_pkg::ST_OK;
		endfunction

		// Binary search from the cursor; the window never stretches further
		// than the distance between the target and the last returned ID.
		function sidlc_pkg::status_t seek(bit [63:0] target);
			int unsigned len, lo, hi, mid;
			bit [63:0]   span, val;
			bit          found;
			len = active_len();
			if (at_end)
				return sidlc_pkg::ST_END;
			if (next_pos >= len || target > id_mem[len - 1]) begin
				at_end = 1'b1;
				return sidlc_pkg::ST_END;
			end
			if (target <= last_id)
				return sidlc_pkg::ST_ORDER;
			span = target - last_id;
			lo = next_pos;
			hi = (span >= 64'(len - next_pos)) ? len : next_pos + span[10:0];
			found = 1'b0;
			mid = lo;
			val = '0;
			do begin
				mid = (lo + hi) / 2;
				val = id_mem[mid];
				if (val == target)
					found = 1'b1;
				else if (target < val)
					hi = mid;
				else
					lo = mid + 1;
			end while (!found && lo < hi);
			// Landed below the target: step on to the next larger entry
			if (val < target) begin
				mid++;
				if (mid >= len) begin
					at_end = 1'b1;
					return sidlc_pkg::ST_END;
				end
				val = id_mem[mid];
			end
			next_pos = mid + 1;
			last_id = val;
			return (val == target) ? sidlc_pkg::ST_OK : sidlc_pkg::ST_NOTFOUND;
		endfunction

		function void note_command(sidlc_pkg::cmd_t c, bit [9:0] idx, bit [63:0] id);
			cursor_result_t r;
			r.st = sidlc_pkg::ST_OK;
			case (c)
				sidlc_pkg::CMD_LOAD: id_mem[idx] = id;
				sidlc_pkg::CMD_READ: r.st = read_next();
				sidlc_pkg::CMD_SKIP: r.st = seek(id);
				default: begin
					at_end = 1'b0;
					last_id = '0;
					next_pos = '0;
				end
			endcase
			r.id = last_id;
			r.pos = next_pos;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [63:0] id, logic [10:0] pos);
			cursor_result_t r;
			if (awaited.size() == 0) begin
				$error("result with none awaited: status %0d, id %h, position %0d",
					st, id, pos);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (st !== r.st) begin
				$error("status mismatch: expected %0d, actual %0d", r.st, st);
				errors++;
			end
			if (id !== r.id) begin
				$error("current_id mismatch: expected %h, actual %h", r.id, id);
				errors++;
			end
			if (pos !== r.pos) begin
				$error("cursor_position mismatch: expected %0d, actual %0d", r.pos, pos);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n          = 1'b0;
	logic                           cfg_write_en    = 1'b0;
	logic [sidlc_pkg::POS_W-1:0]    cfg_write_data  = '0;
	logic                           in_valid        = 1'b0;
	logic                           in_stall;
	logic [1:0]                     command         = sidlc_pkg::CMD_READ;
	logic [sidlc_pkg::IDX_W-1:0]    entry_index     = '0;
	logic [sidlc_pkg::OUT_ID_W-1:0] doc_id          = '0;
	logic                           out_valid;
	logic                           out_stall       = 1'b0;
	logic [1:0]                     status;
	logic [sidlc_pkg::OUT_ID_W-1:0] current_id;
	logic [sidlc_pkg::POS_W-1:0]    cursor_position;

	cursor_checker tracker;

	// Sender burst state; steady suppresses gaps for a whole phase
	int       burst_left = 0;
	bit       steady     = 1'b0;
	int       sent       = 0;

	// Receiver stall state
	rx_mode_t rx_mode    = FLOW_FREE;
	int       mode_left  = 0;
	int       stall_run  = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	sorted_id_list_cursor_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.entry_index     (entry_index),
		.doc_id          (doc_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.current_id      (current_id),
		.cursor_position (cursor_position)
	);

	function automatic bit [63:0] any_id();
		return {$urandom, $urandom};
	endfunction

	// Present one transaction and hold it until the block takes it. Open a
	// new burst after a random gap unless the phase runs without gaps. The
	// model advances here, right at acceptance, so the next pick of a skip
	// target sees the cursor as it now stands.
	task automatic send_command(sidlc_pkg::cmd_t c, bit [9:0] idx, bit [63:0] id);
		int gap;
		if (!steady && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= c;
		entry_index <= idx;
		doc_id <= id;
		do @(posedge clk); while (in_stall);
		tracker.note_command(c, idx, id);
		sent++;
	endtask

	// Drop valid and wait until every queued result has been delivered
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
		burst_left = 0;
	endtask

	// The length register may only change with the block idle
	task automatic set_list_length(bit [10:0] len);
		hold_until_drained();
		cfg_write_en <= 1'b1;
		cfg_write_data <= len;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		tracker.list_len = len;
	endtask

	// Load entries 0..count-1 with a strictly increasing list
	task automatic load_sorted(int unsigned count, spacing_t spacing);
		bit [63:0] id, step_max;
		case (spacing)
			GAP_DENSE: begin
				id = $urandom_range(0, 3);
				step_max = 2;
			end
			GAP_NARROW: begin
				id = {32'd0, $urandom};
				step_max = 100;
			end
			GAP_WIDE: begin
				id = any_id() >> 2;
				step_max = 64'd1 << 40;
			end
			default: begin
				// Crowd the list against the top of the ID space
				id = '1 - 64'(count) * 1000 - $urandom_range(0, 999);
				step_max = 1000;
			end
		endcase
		for (int unsigned i = 0; i < count; i++) begin
			if (spacing == GAP_TOP && i == count - 1 && $urandom_range(0, 1) == 1)
				id = '1;
			send_command(sidlc_pkg::CMD_LOAD, 10'(i), id);
			id += 1 + any_id() % step_max;
		end
	endtask

	// One cursor transaction shaped by where the cursor stands: mostly reads
	// and skips aimed at entries ahead of it, plus rewinds, stray loads and
	// targets that land between entries, past the list or behind the cursor.
	task automatic random_op();
		int unsigned len, pick, j, lo_j;
		bit [63:0]   target;
		len = tracker.active_len();
		pick = $urandom_range(0, 99);
		if (pick < 2)
			hold_until_drained();
		// Rewind more often once stuck at the end
		if (tracker.at_end && $urandom_range(0, 2) == 0)
			pick = 85;
		if (pick < 32)
			send_command(sidlc_pkg::CMD_READ, 10'($urandom), any_id());
		else if (pick < 82) begin
			if (len == 0)
				target = any_id();
			else begin
				lo_j = (tracker.next_pos < len) ? tracker.next_pos : len - 1;
				if ($urandom_range(0, 1) == 0)
					j = $urandom_range(lo_j, len - 1);
				else
					j = $urandom_range(lo_j, (lo_j + 3 < len) ? lo_j + 3 : len - 1);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: target = tracker.id_mem[j];
					4, 5: target = tracker.id_mem[j] + 1;
					6: target = tracker.id_mem[j] - 1;
					7: target = tracker.id_mem[len - 1] + $urandom_range(1, 5);
					8: target = tracker.last_id - $urandom_range(0, 2);
					default: target = any_id();
				endcase
			end
			send_command(sidlc_pkg::CMD_SKIP, 10'($urandom), target);
		end else if (pick < 92)
			send_command(sidlc_pkg::CMD_REWIND, 10'($urandom), any_id());
		else if (len != 0 && pick < 96) begin
			// Rewrite an entry with its own value: order kept
			j = $urandom_range(0, len - 1);
			send_command(sidlc_pkg::CMD_LOAD, 10'(j), tracker.id_mem[j]);
		end else
			send_command(sidlc_pkg::CMD_LOAD, 10'($urandom), any_id());
	endtask

	// Check each delivered result, then pick the stall for the next cycle.
	// The pattern is drawn at random: free flow, coin flips,
	// long runs of stall and release, or the odd single stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(status, current_id, cursor_position);
		if (mode_left <= 0) begin
			mode_left = $urandom_range(50, 300);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		end
		mode_left--;
		case (rx_mode)
			FLOW_FREE: out_stall <= 1'b0;
			FLOW_COIN: out_stall <= ($urandom_range(0, 1) == 1);
			FLOW_RUNS: begin
				if (stall_run <= 0) begin
					stall_run = $urandom_range(1, 16);
					out_stall <= !out_stall;
				end
				stall_run--;
			end
			default: out_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Watchdog: end the run once nothing has moved on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned len;
		int unsigned ops;
		tracker = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list straight after reset: read and skip both hit the end
		send_command(sidlc_pkg::CMD_READ, '0, '0);
		send_command(sidlc_pkg::CMD_SKIP, '1, '1);
		send_command(sidlc_pkg::CMD_REWIND, '0, '0);
		// Top index with the top ID, then a short list 10, 20, 30, 40
		send_command(sidlc_pkg::CMD_LOAD, 10'd1023, '1);
		send_command(sidlc_pkg::CMD_LOAD, 10'd0, 64'd10);
		send_command(sidlc_pkg::CMD_LOAD, 10'd1, 64'd20);
		send_command(sidlc_pkg::CMD_LOAD, 10'd2, 64'd30);
		send_command(sidlc_pkg::CMD_LOAD, 10'd3, 64'd40);
		set_list_length(11'd4);
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd20);     // exact hit
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd20);     // target not above last ID
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd25);     // lands on the next larger ID
		send_command(sidlc_pkg::CMD_READ, '0, '0);         // last entry
		send_command(sidlc_pkg::CMD_READ, '0, '0);         // runs off the end
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd50);     // already at the end
		send_command(sidlc_pkg::CMD_REWIND, '0, '0);
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd41);     // beyond the last entry
		send_command(sidlc_pkg::CMD_REWIND, '0, '0);
		send_command(sidlc_pkg::CMD_READ, '0, '0);
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd0);      // behind the cursor
		send_command(sidlc_pkg::CMD_SKIP, '0, 64'd11);     // one-entry window, not found

		// Short lists: mostly well-formed, some with entries overwritten out
		// of order, each followed by a run of cursor traffic
		while (sent < 200) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: len = 1;
				1: len = 2;
				2: len = 0;
				default: len = $urandom_range(3, 40);
			endcase
			set_list_length(11'(len));
			if (len != 0) begin
				load_sorted(len, spacing_t'($urandom_range(0, 3)));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						send_command(sidlc_pkg::CMD_LOAD,
							10'($urandom_range(0, len - 1)), any_id());
			end
			ops = $urandom_range(15, 50);
			repeat (ops) random_op();
		end

		// Full store, then a length above the depth that must act as full
		steady = 1'b0;
		set_list_length(11'd1024);
		load_sorted(DEPTH, spacing_t'($urandom_range(1, 3)));
		repeat (120) random_op();
		set_list_length(11'd2047);
		repeat (80) random_op();
		set_list_length(11'd0);
		repeat (6) random_op();

		// Let the last results out, then allow a skip's worth of cycles for strays
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
design/sidlc_pkg.sv
design/sidlc_dpath.sv
design/sidlc_ctrl.sv
design/sorted_id_list_cursor_top.sv
test/testbench.sv
